// ===== sv/vsm_pkg.sv =====
// Package: shared constants and types for the variance soft mask block.
package vsm_pkg;
  localparam int SOURCES_D     = 4;
  localparam int BINS_D        = 1024;
  localparam int MAX_HISTORY_D = 16;
  localparam int MAG_BITS_D    = 24;
  localparam int HIST_RESET    = 8;
  localparam int Q_BITS        = 16;

  typedef enum logic [3:0] {
    ST_IDLE, ST_STORE, ST_RD, ST_ACC, ST_SQ, ST_NVAR, ST_S1SQ, ST_SUB,
    ST_DIVCHK, ST_DIV, ST_OUT
  } state_t;
endpackage

// ===== sv/vsm_ram.sv =====
// Generic single-port RAM with registered read.
module vsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== sv/variance_soft_mask_top.sv =====
// Top level: variance soft mask over per-cell history windows.
//
// One request is taken at a time. For a cell with n > 1 stored frames the
// block reads back the estimate window and then the residual window, one entry
// at a time (read, accumulate, square), forms n*S2 - S1*S1 for each window,
// squaring on one shared 32x32 multiplier, then runs a 16-step restoring
// divider. The divider is skipped when the denominator is zero or the ratio
// reaches one. The shared multiplier and the single-port window memories
// serialise the work. After reset, and after every write of history_size, a
// clearing pass over the SOURCES*BINS per-cell counters runs with in_tready
// low. Bins or sources out of range return mask 0 and leave the state
// unchanged.
module variance_soft_mask_top import vsm_pkg::*; #(
  parameter int SOURCES     = SOURCES_D,
  parameter int BINS        = BINS_D,
  parameter int MAX_HISTORY = MAX_HISTORY_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // source_index[1:0], bin_index[11:2], mixture[35:12], estimate[59:36], pad
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // source_echo[1:0], bin_echo[11:2], mask[31:12] (unsigned, 16 fraction bits)
  output logic [31:0] out_tdata
);
  localparam int MAG_BITS = MAG_BITS_D;
  localparam int CELLS = SOURCES * BINS;
  localparam int CB    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int HB    = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int NB    = $clog2(MAX_HISTORY + 1);
  localparam int WB    = CB + HB;
  localparam int RB    = MAG_BITS + 1;
  localparam int S1B   = RB + HB + 1;
  localparam int WIDE  = 2 * S1B + 2 * NB + 2;

  state_t state_r, state_nxt;

  logic [4:0]  hist_r;
  logic [CB:0] clr_r;
  logic        clearing;
  assign clearing = (clr_r != '0);

  // Captured request.
  logic [1:0]          src_r;
  logic [9:0]          bin_r;
  logic [MAG_BITS-1:0] mix_r, est_r;
  logic                inr_r;
  logic [CB-1:0]       cell_r;
  logic [NB-1:0]       hs_r, n_r;
  logic [NB-1:0]       j_r;
  logic                pass_r;   // 0 estimate window, 1 residual window
  logic                rdv_r;

  // Per-cell counters in RAM: {frames_stored, write_slot}.
  logic           cnt_we;
  logic [CB-1:0]  cnt_addr;
  logic [NB+HB-1:0] cnt_wd, cnt_rd;

  // Windows.
  logic               win_we;
  logic [WB-1:0]      win_addr;
  logic [MAG_BITS-1:0] ew_rd;
  logic [RB-1:0]      rw_rd;
  logic signed [RB-1:0] res_val;
  assign res_val = RB'(mix_r) - RB'(est_r);

  vsm_ram #(.WIDTH(NB+HB), .DEPTH(CELLS)) u_cnt (
    .clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wd), .rdata(cnt_rd));
  vsm_ram #(.WIDTH(MAG_BITS), .DEPTH(CELLS * (2 ** HB))) u_est (
    .clk(clk), .we(win_we), .addr(win_addr), .wdata(est_r), .rdata(ew_rd));
  vsm_ram #(.WIDTH(RB), .DEPTH(CELLS * (2 ** HB))) u_res (
    .clk(clk), .we(win_we), .addr(win_addr), .wdata(res_val), .rdata(rw_rd));

  // Accumulators and shared multiplier.
  logic signed [S1B-1:0] s1_r;
  logic [WIDE-1:0]       s2_r, a_r, num_r, den_r;
  logic [RB-1:0]         sqa_r;
  logic [S1B-1:0]        abs1;
  logic [4:0]            k_r;
  logic [Q_BITS:0]       q_r;
  logic [63:0]           mul_p;
  logic [31:0]           mul_x, mul_y;
  assign mul_p = 64'(mul_x) * 64'(mul_y);

  logic [NB-1:0] hs_eff;
  always_comb begin
    if (hist_r == 5'd0) hs_eff = NB'(1);
    else if (32'(hist_r) > MAX_HISTORY) hs_eff = NB'(MAX_HISTORY);
    else hs_eff = NB'(hist_r);
  end

  logic [HB-1:0] slot_use;
  logic [NB-1:0] fs_old;
  assign fs_old   = cnt_rd[NB+HB-1:HB];
  assign slot_use = (NB'(cnt_rd[HB-1:0]) >= hs_r) ? HB'(0) : cnt_rd[HB-1:0];
  assign abs1     = s1_r[S1B-1] ? S1B'(-s1_r) : S1B'(s1_r);

  logic [WIDE-1:0] num_sh;
  assign num_sh = {num_r[WIDE-2:0], 1'b0};

  always_comb begin
    state_nxt = state_r;
    cnt_we = 1'b0;
    cnt_addr = cell_r;
    cnt_wd = '0;
    win_we = 1'b0;
    win_addr = {cell_r, j_r[HB-1:0]};
    mul_x = 32'(sqa_r);
    mul_y = 32'(sqa_r);
    if (clearing) begin
      cnt_we = 1'b1;
      cnt_addr = clr_r[CB-1:0] - CB'(1);
    end
    case (state_r)
      ST_IDLE: if (in_tvalid && in_tready) state_nxt = ST_STORE;
      ST_STORE: begin
        if (!inr_r) state_nxt = ST_OUT;
        else if (rdv_r) begin
          // Write new sample, bump counters.
          win_we = 1'b1;
          win_addr = {cell_r, slot_use};
          cnt_we = 1'b1;
          cnt_wd = {(fs_old < hs_r) ? NB'(fs_old + NB'(1)) : hs_r,
                    (NB'(slot_use) + NB'(1) >= hs_r) ? HB'(0) : HB'(slot_use + HB'(1))};
          state_nxt = ST_RD;
        end
      end
      ST_RD: state_nxt = ST_ACC;
      ST_ACC: state_nxt = ST_SQ;
      ST_SQ: state_nxt = (j_r == n_r) ? ST_NVAR : ST_RD;
      ST_NVAR: state_nxt = ST_S1SQ;
      ST_S1SQ: begin
        mul_x = 32'(abs1);
        mul_y = 32'(abs1);
        state_nxt = ST_SUB;
      end
      ST_SUB: state_nxt = (pass_r || n_r == NB'(1)) ? ST_DIVCHK : ST_RD;
      ST_DIVCHK: state_nxt = (den_r == '0 || num_r >= den_r) ? ST_OUT : ST_DIV;
      ST_DIV: if (k_r == 5'(Q_BITS - 1)) state_nxt = ST_OUT;
      ST_OUT: if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hist_r  <= 5'(HIST_RESET);
      clr_r   <= (CB+1)'(CELLS);
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        hist_r <= cfg_wdata;
        clr_r  <= (CB+1)'(CELLS);
      end else if (clearing) begin
        clr_r <= clr_r - (CB+1)'(1);
      end
      // Counter read data is valid in ST_STORE once rdv_r is set, as the counter RAM read is registered.
      rdv_r <= (state_r == ST_STORE) && !rdv_r;
    end
  end

  logic [WIDE-1:0] prod_w;
  assign prod_w = WIDE'(mul_p);

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        src_r <= in_tdata[1:0];
        bin_r <= in_tdata[11:2];
        mix_r <= in_tdata[12 +: MAG_BITS];
        est_r <= in_tdata[36 +: MAG_BITS];
        inr_r <= (32'(in_tdata[1:0]) < SOURCES) && (32'(in_tdata[11:2]) < BINS);
        cell_r <= CB'(32'(in_tdata[1:0]) * BINS + 32'(in_tdata[11:2]));
        hs_r  <= hs_eff;
        q_r   <= '0;
      end
      ST_STORE: if (rdv_r) begin
        n_r <= (fs_old < hs_r) ? NB'(fs_old + NB'(1)) : hs_r;
        j_r <= '0;
        pass_r <= 1'b0;
        s1_r <= '0;
        s2_r <= '0;
        if (fs_old == '0 || hs_r == NB'(1)) begin
          // One frame: raw estimate over mixture.
          num_r <= WIDE'(est_r);
          den_r <= WIDE'(mix_r);
        end
      end
      ST_RD: ;
      ST_ACC: begin
        if (!pass_r) begin
          s1_r  <= s1_r + S1B'(ew_rd);
          sqa_r <= RB'(ew_rd);
        end else begin
          s1_r  <= s1_r + S1B'($signed(rw_rd));
          sqa_r <= rw_rd[RB-1] ? RB'(-rw_rd) : rw_rd;
        end
        j_r <= j_r + NB'(1);
      end
      ST_SQ: s2_r <= s2_r + prod_w;
      ST_NVAR: s2_r <= WIDE'(s2_r * WIDE'(n_r));
      ST_S1SQ: a_r <= prod_w;
      ST_SUB: if (n_r != NB'(1)) begin
        if (!pass_r) begin
          num_r <= s2_r - a_r;
          pass_r <= 1'b1;
        end else den_r <= num_r + (s2_r - a_r);
        j_r <= '0;
        s1_r <= '0;
        s2_r <= '0;
      end
      ST_DIVCHK: begin
        k_r <= '0;
        if (den_r == '0) q_r <= '0;
        else if (num_r >= den_r) q_r <= (Q_BITS+1)'(1 << Q_BITS);
      end
      ST_DIV: begin
        k_r <= k_r + 5'd1;
        if (num_sh >= den_r) begin
          num_r <= num_sh - den_r;
          q_r <= {q_r[Q_BITS-1:0], 1'b1};
        end else begin
          num_r <= num_sh;
          q_r <= {q_r[Q_BITS-1:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE) && !clearing && !cfg_we;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {20'(q_r), bin_r, src_r};
endmodule
